[src/scr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scr_pkg
// Types and widths shared by the stick constraint relaxation pipeline.
// ----------------------------------------------------------------------------
package scr_pkg;

   localparam int COORD_W    = 24;
   localparam int REST_W     = 23;
   localparam int GUARD_BITS = 7;
   localparam int D_W        = COORD_W + 1;
   localparam int SQ_W       = 2 * D_W;
   localparam int RAD_W      = 64;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int M_W        = ROOT_W + 2;
   localparam int AM_W       = ROOT_W + 1;
   localparam int LO_W       = 17;
   localparam int HI_W       = AM_W - LO_W;
   localparam int NUM_W      = D_W + AM_W + 1;
   localparam int Q_W        = 26;
   localparam int OFF_W      = Q_W + 1;
   localparam int SUM_W      = OFF_W + 1;

   // pipeline stage positions
   localparam int ST_ROOT = 3;
   localparam int ST_MUL  = ST_ROOT + ROOT_STEPS + 3;
   localparam int ST_DIV  = ST_MUL;
   localparam int NST     = ST_DIV + Q_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] end_a_x;
      logic signed [COORD_W-1:0] end_a_y;
      logic signed [COORD_W-1:0] end_b_x;
      logic signed [COORD_W-1:0] end_b_y;
      logic [REST_W-1:0]         rest_length;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] new_a_x;
      logic signed [COORD_W-1:0] new_a_y;
      logic signed [COORD_W-1:0] new_b_x;
      logic signed [COORD_W-1:0] new_b_y;
      logic                      degenerate;
      logic                      clipped;
   } rsp_type;

   typedef struct packed {
      req_type        item;
      logic           degen;
      logic           neg_x;
      logic           neg_y;
      logic [D_W-1:0] adx;
      logic [D_W-1:0] ady;
   } ctx_type;

endpackage
`default_nettype wire

[src/stick_constraint_relax.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stick_constraint_relax
// Distance constraint relaxation of one stick: root, scale, offset, saturate.
// ----------------------------------------------------------------------------
// One item per cycle while no result waits in the skid; one root digit per
// stage, or one quotient bit per coordinate, needs one compare and subtract.
// A two-entry output register and skid let the pipe run while a result waits.
// Reset clears all valid bits; payload registers are not reset.
module stick_constraint_relax
   import scr_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_item
);

   logic           en;
   logic [NST-1:0] vld_ff;

   // stage 1
   ctx_type                 ctx1_ff, ctx1_in;
   logic signed [D_W-1:0]   dx_in, dy_in;
   // stage 2
   ctx_type                 ctx2_ff;
   logic [SQ_W-1:0]         sqx2_ff, sqy2_ff;
   // stage 3
   ctx_type                 ctx3_ff;
   logic [RAD_W-1:0]        v3_ff;
   // root stages
   ctx_type                 ctxs_ff [ROOT_STEPS];
   logic [RAD_W-1:0]        sv_ff [ROOT_STEPS];
   logic [RAD_W-1:0]        sr_ff [ROOT_STEPS];
   logic [RAD_W-1:0]        sv_in [ROOT_STEPS];
   logic [RAD_W-1:0]        sr_in [ROOT_STEPS];
   logic [RAD_W-1:0]        st_tmp [ROOT_STEPS];
   // scale stage
   ctx_type                 ctx4_ff, ctx4_in;
   logic [AM_W-1:0]         am4_ff, am4_in;
   logic [ROOT_W-1:0]       de4_ff;
   logic signed [M_W-1:0]   m_in;
   // partial products
   ctx_type                 ctx5_ff;
   logic [D_W+LO_W-1:0]     pxl5_ff, pyl5_ff;
   logic [D_W+HI_W-1:0]     pxh5_ff, pyh5_ff;
   logic [ROOT_W-1:0]       de5_ff;
   // numerator
   ctx_type                 ctx6_ff;
   logic [NUM_W-1:0]        nx6_ff, ny6_ff;
   logic [AM_W-1:0]         den6_ff;
   // divide stages
   ctx_type                 ctxd_ff [Q_W];
   logic [NUM_W-1:0]        rx_ff [Q_W];
   logic [NUM_W-1:0]        ry_ff [Q_W];
   logic [Q_W-1:0]          qx_ff [Q_W];
   logic [Q_W-1:0]          qy_ff [Q_W];
   logic [AM_W-1:0]         dden_ff [Q_W];
   logic [NUM_W-1:0]        rx_in [Q_W];
   logic [NUM_W-1:0]        ry_in [Q_W];
   logic [Q_W-1:0]          qx_in [Q_W];
   logic [Q_W-1:0]          qy_in [Q_W];
   logic [NUM_W-1:0]        trial [Q_W];
   // final stage
   rsp_type                 res_ff, res_in;
   logic signed [OFF_W-1:0] ox, oy;
   logic [COORD_W:0]        sat_ax, sat_ay, sat_bx, sat_by;
   // output register and skid
   logic                    out_v_ff, skid_v_ff, last_go;
   rsp_type                 out_ff, skid_ff;

   function automatic logic [COORD_W:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi, lo;
      hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
      lo = -SUM_W'(64'sd1 <<< (COORD_W - 1));
      if (v > hi) begin
         sat = {1'b1, hi[COORD_W-1:0]};
      end else if (v < lo) begin
         sat = {1'b1, lo[COORD_W-1:0]};
      end else begin
         sat = {1'b0, v[COORD_W-1:0]};
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] sx(input logic signed [COORD_W-1:0] v);
      sx = SUM_W'(v);
   endfunction

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign last_go   = vld_ff[NST-1] && en;
   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stage 1: differences
   always_comb begin
      dx_in = D_W'(req_item.end_a_x) - D_W'(req_item.end_b_x);
      dy_in = D_W'(req_item.end_a_y) - D_W'(req_item.end_b_y);
      ctx1_in.item  = req_item;
      ctx1_in.degen = (dx_in == '0) && (dy_in == '0);
      ctx1_in.neg_x = dx_in[D_W-1];
      ctx1_in.neg_y = dy_in[D_W-1];
      ctx1_in.adx   = dx_in[D_W-1] ? D_W'(-dx_in) : D_W'(dx_in);
      ctx1_in.ady   = dy_in[D_W-1] ? D_W'(-dy_in) : D_W'(dy_in);
   end

   // root iterations, one result bit per stage
   always_comb begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         sv_in[k]  = (k == 0) ? v3_ff : sv_ff[(k == 0) ? 0 : k - 1];
         sr_in[k]  = (k == 0) ? '0 : sr_ff[(k == 0) ? 0 : k - 1];
         st_tmp[k] = sr_in[k] + (RAD_W'(1) << (RAD_W - 2 - 2 * k));
         if (sv_in[k] >= st_tmp[k]) begin
            sv_in[k] = sv_in[k] - st_tmp[k];
            sr_in[k] = (sr_in[k] >> 1) + (RAD_W'(1) << (RAD_W - 2 - 2 * k));
         end else begin
            sr_in[k] = sr_in[k] >> 1;
         end
      end
   end

   // scale: m = rest * 2^g - De
   always_comb begin
      m_in = M_W'({ctxs_ff[ROOT_STEPS-1].item.rest_length, GUARD_BITS'(0)})
           - M_W'(sr_ff[ROOT_STEPS-1][ROOT_W-1:0]);
      am4_in = m_in[M_W-1] ? AM_W'(-m_in) : AM_W'(m_in);
      ctx4_in = ctxs_ff[ROOT_STEPS-1];
      ctx4_in.neg_x = ctxs_ff[ROOT_STEPS-1].neg_x ^ m_in[M_W-1];
      ctx4_in.neg_y = ctxs_ff[ROOT_STEPS-1].neg_y ^ m_in[M_W-1];
   end

   // restoring divide, one quotient bit per stage
   always_comb begin
      for (int i = 0; i < Q_W; i++) begin
         rx_in[i] = (i == 0) ? nx6_ff : rx_ff[(i == 0) ? 0 : i - 1];
         ry_in[i] = (i == 0) ? ny6_ff : ry_ff[(i == 0) ? 0 : i - 1];
         qx_in[i] = (i == 0) ? '0 : qx_ff[(i == 0) ? 0 : i - 1];
         qy_in[i] = (i == 0) ? '0 : qy_ff[(i == 0) ? 0 : i - 1];
         trial[i] = NUM_W'((i == 0) ? den6_ff : dden_ff[(i == 0) ? 0 : i - 1])
                  << (Q_W - 1 - i);
         if (rx_in[i] >= trial[i]) begin
            rx_in[i] = rx_in[i] - trial[i];
            qx_in[i] = qx_in[i] | (Q_W'(1) << (Q_W - 1 - i));
         end
         if (ry_in[i] >= trial[i]) begin
            ry_in[i] = ry_in[i] - trial[i];
            qy_in[i] = qy_in[i] | (Q_W'(1) << (Q_W - 1 - i));
         end
      end
   end

   // offsets, sums, saturation
   always_comb begin
      ox = ctxd_ff[Q_W-1].neg_x ? -$signed({1'b0, qx_ff[Q_W-1]})
                                 :  $signed({1'b0, qx_ff[Q_W-1]});
      oy = ctxd_ff[Q_W-1].neg_y ? -$signed({1'b0, qy_ff[Q_W-1]})
                                 :  $signed({1'b0, qy_ff[Q_W-1]});
      sat_ax = sat(sx(ctxd_ff[Q_W-1].item.end_a_x) + SUM_W'(ox));
      sat_ay = sat(sx(ctxd_ff[Q_W-1].item.end_a_y) + SUM_W'(oy));
      sat_bx = sat(sx(ctxd_ff[Q_W-1].item.end_b_x) - SUM_W'(ox));
      sat_by = sat(sx(ctxd_ff[Q_W-1].item.end_b_y) - SUM_W'(oy));
      if (ctxd_ff[Q_W-1].degen) begin
         res_in.new_a_x = ctxd_ff[Q_W-1].item.end_a_x;
         res_in.new_a_y = ctxd_ff[Q_W-1].item.end_a_y;
         res_in.new_b_x = ctxd_ff[Q_W-1].item.end_b_x;
         res_in.new_b_y = ctxd_ff[Q_W-1].item.end_b_y;
         res_in.degenerate = 1'b1;
         res_in.clipped    = 1'b0;
      end else begin
         res_in.new_a_x = sat_ax[COORD_W-1:0];
         res_in.new_a_y = sat_ay[COORD_W-1:0];
         res_in.new_b_x = sat_bx[COORD_W-1:0];
         res_in.new_b_y = sat_by[COORD_W-1:0];
         res_in.degenerate = 1'b0;
         res_in.clipped    = sat_ax[COORD_W] | sat_ay[COORD_W]
                           | sat_bx[COORD_W] | sat_by[COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx1_ff <= ctx1_in;
         ctx2_ff <= ctx1_ff;
         sqx2_ff <= SQ_W'(ctx1_ff.adx * ctx1_ff.adx);
         sqy2_ff <= SQ_W'(ctx1_ff.ady * ctx1_ff.ady);
         ctx3_ff <= ctx2_ff;
         v3_ff   <= RAD_W'(sqx2_ff + sqy2_ff) << (2 * GUARD_BITS);
         for (int k = 0; k < ROOT_STEPS; k++) begin
            ctxs_ff[k] <= (k == 0) ? ctx3_ff : ctxs_ff[(k == 0) ? 0 : k - 1];
            sv_ff[k]   <= sv_in[k];
            sr_ff[k]   <= sr_in[k];
         end
         ctx4_ff <= ctx4_in;
         am4_ff  <= am4_in;
         de4_ff  <= sr_ff[ROOT_STEPS-1][ROOT_W-1:0];
         ctx5_ff <= ctx4_ff;
         pxl5_ff <= (D_W+LO_W)'(ctx4_ff.adx * am4_ff[LO_W-1:0]);
         pyl5_ff <= (D_W+LO_W)'(ctx4_ff.ady * am4_ff[LO_W-1:0]);
         pxh5_ff <= (D_W+HI_W)'(ctx4_ff.adx * am4_ff[AM_W-1:LO_W]);
         pyh5_ff <= (D_W+HI_W)'(ctx4_ff.ady * am4_ff[AM_W-1:LO_W]);
         de5_ff  <= de4_ff;
         ctx6_ff <= ctx5_ff;
         nx6_ff  <= NUM_W'(pxl5_ff) + (NUM_W'(pxh5_ff) << LO_W) + NUM_W'(de5_ff);
         ny6_ff  <= NUM_W'(pyl5_ff) + (NUM_W'(pyh5_ff) << LO_W) + NUM_W'(de5_ff);
         den6_ff <= {de5_ff, 1'b0};
         for (int i = 0; i < Q_W; i++) begin
            ctxd_ff[i] <= (i == 0) ? ctx6_ff : ctxd_ff[(i == 0) ? 0 : i - 1];
            dden_ff[i] <= (i == 0) ? den6_ff : dden_ff[(i == 0) ? 0 : i - 1];
            rx_ff[i]   <= rx_in[i];
            ry_ff[i]   <= ry_in[i];
            qx_ff[i]   <= qx_in[i];
            qy_ff[i]   <= qy_in[i];
         end
         res_ff <= res_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         out_v_ff  <= skid_v_ff || last_go;
         skid_v_ff <= 1'b0;
      end else if (last_go) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ready) begin
         out_ff <= skid_v_ff ? skid_ff : res_ff;
      end else if (last_go) begin
         skid_ff <= res_ff;
      end
   end

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without a pending result");

   a_degen_no_clip: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.degenerate |-> !out_ff.clipped)
      else $error("degenerate result flagged as clipped");

   a_degen_detect: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.end_a_x == req_item.end_b_x)
      && (req_item.end_a_y == req_item.end_b_y) |=> vld_ff[0] && ctx1_ff.degen)
      else $error("coincident ends not marked degenerate");
`endif

endmodule
`default_nettype wire
